@@ rtl/checked_integer_alu_top_defines.svh @@
// Assertion macros for the checked integer ALU.
// Taken in by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CHECKED_INTEGER_ALU_TOP_DEFINES_SVH
`define CHECKED_INTEGER_ALU_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checked_integer_alu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checked_integer_alu: next-cycle check failed");

`endif

@@ rtl/cia_pkg.sv @@
// Shared types and constants for the checked integer ALU.
// Used by every module of the block; depends on nothing.
package cia_pkg;

    // Operand width; the request and response fields are fixed at this width.
    localparam int WIDTH = 32;

    localparam logic [WIDTH-1:0] MIN_NEG = {1'b1, {(WIDTH-1){1'b0}}};

    // Operation codes of a request.
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4
    } t_op;

    // What the cell chain does with an item.
    typedef enum logic [1:0] {
        K_PASS = 2'd0,
        K_MUL  = 2'd1,
        K_DIV  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [2:0]       req_type;
        logic             is_signed;
        logic [WIDTH-1:0] operand_a;
        logic [WIDTH-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [WIDTH-1:0] result_value;
        logic             overflow;
    } t_rsp;

    // Data handed from cell to cell. For multiply, r is the high product half
    // and x the multiplier shifting out while low product bits shift in. For
    // divide, r is the partial remainder and x the dividend shifting out while
    // quotient bits shift in. For pass, r holds the finished result.
    typedef struct packed {
        t_kind            kind;
        logic             is_signed;
        logic             negres;
        logic             ovf;
        logic [WIDTH-1:0] r;
        logic [WIDTH-1:0] x;
        logic [WIDTH-1:0] y;
    } t_stage;

endpackage

@@ rtl/cia_prep.sv @@
// Front stage of the checked integer ALU: decodes a request, finishes the short
// operations and prepares magnitudes for the cell chain. Depends on cia_pkg.
module cia_prep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cia_pkg::t_req   i_req,
    output logic            o_stall,
    output logic            o_valid,
    output cia_pkg::t_stage o_data,
    input  logic            i_stall
);

    localparam int W = cia_pkg::WIDTH;

    logic            r_valid;
    cia_pkg::t_stage r_data;
    cia_pkg::t_stage n_data;

    logic [W-1:0] a, b, ma, mb;
    logic         sg;
    logic [W:0]   sum;
    logic [W-1:0] dif;

    // Decode and the short operations.
    always_comb begin
        a   = i_req.operand_a;
        b   = i_req.operand_b;
        sg  = i_req.is_signed;
        ma  = (sg && a[W-1]) ? (~a + 1'b1) : a;
        mb  = (sg && b[W-1]) ? (~b + 1'b1) : b;
        sum = {1'b0, a} + {1'b0, b};
        dif = a - b;

        n_data           = '0;
        n_data.kind      = cia_pkg::K_PASS;
        n_data.is_signed = sg;
        n_data.negres    = sg && (a[W-1] ^ b[W-1]);

        case (i_req.req_type)
            cia_pkg::OP_ADD: begin
                n_data.ovf = sg ? (!(a[W-1] ^ b[W-1]) && (sum[W-1] ^ a[W-1])) : sum[W];
                n_data.r   = n_data.ovf ? '0 : sum[W-1:0];
            end
            cia_pkg::OP_SUB: begin
                n_data.ovf = sg ? ((a[W-1] ^ b[W-1]) && (dif[W-1] ^ a[W-1])) : (a < b);
                n_data.r   = n_data.ovf ? '0 : dif;
            end
            cia_pkg::OP_MUL: begin
                n_data.kind = cia_pkg::K_MUL;
                n_data.x    = ma;
                n_data.y    = mb;
            end
            cia_pkg::OP_DIV: begin
                // Division by zero and the most negative value over minus one
                // are settled here; everything else enters the chain.
                if ((b == '0) || (sg && (a == cia_pkg::MIN_NEG) && (b == '1))) begin
                    n_data.ovf = 1'b1;
                end else begin
                    n_data.kind = cia_pkg::K_DIV;
                    n_data.x    = ma;
                    n_data.y    = mb;
                end
            end
            cia_pkg::OP_NEG: begin
                n_data.negres = 1'b0;
                if (sg) begin
                    n_data.ovf = (a == cia_pkg::MIN_NEG);
                    n_data.r   = n_data.ovf ? '0 : (~a + 1'b1);
                end else begin
                    n_data.ovf = (a != '0);
                end
            end
            default: begin
                n_data.ovf = 1'b1;
            end
        endcase
    end

    // Stage register; it takes a new request unless it holds one that is stalled.
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/cia_cell.sv @@
// One cell of the checked integer ALU chain: a shift-add multiply step or a
// restoring divide step, then a register. Depends on cia_pkg.
module cia_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cia_pkg::t_stage i_data,
    output logic            o_stall,
    output logic            o_valid,
    output cia_pkg::t_stage o_data,
    input  logic            i_stall
);

    localparam int W = cia_pkg::WIDTH;

    logic            r_valid;
    cia_pkg::t_stage r_data;
    cia_pkg::t_stage n_data;

    logic [W:0] sum;
    logic [W:0] rem2;
    logic [W:0] diff;

    // One step of multiply or divide.
    always_comb begin
        sum  = {1'b0, i_data.r} + (i_data.x[0] ? {1'b0, i_data.y} : '0);
        rem2 = {i_data.r, i_data.x[W-1]};
        diff = rem2 - {1'b0, i_data.y};

        n_data = i_data;
        case (i_data.kind)
            cia_pkg::K_MUL: begin
                n_data.r = sum[W:1];
                n_data.x = {sum[0], i_data.x[W-1:1]};
            end
            cia_pkg::K_DIV: begin
                n_data.r = diff[W] ? rem2[W-1:0] : diff[W-1:0];
                n_data.x = {i_data.x[W-2:0], !diff[W]};
            end
            default: begin
                n_data = i_data;
            end
        endcase
    end

    // Cell register with its own valid bit.
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/cia_post.sv @@
// Back stage of the checked integer ALU: range checks on the product, sign
// fix-up of product and quotient, and the response register. Depends on cia_pkg.
module cia_post (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cia_pkg::t_stage i_data,
    output logic            o_stall,
    output logic            o_valid,
    output cia_pkg::t_rsp   o_rsp,
    input  logic            i_stall
);

    localparam int W = cia_pkg::WIDTH;

    logic          r_valid;
    cia_pkg::t_rsp r_rsp;
    cia_pkg::t_rsp n_rsp;

    logic [W-1:0] mag;
    logic         ovf;

    // Final checks and sign of the result.
    always_comb begin
        mag = i_data.x;
        ovf = i_data.ovf;
        case (i_data.kind)
            cia_pkg::K_MUL: begin
                // The product magnitude must fit the signed or unsigned range;
                // a negative result may reach the most negative value.
                if (i_data.is_signed) begin
                    ovf = (i_data.r != '0) ||
                          (i_data.x[W-1] && (!i_data.negres || (i_data.x[W-2:0] != '0)));
                end else begin
                    ovf = (i_data.r != '0);
                end
            end
            cia_pkg::K_DIV: begin
                ovf = 1'b0;
            end
            default: begin
                mag = i_data.r;
            end
        endcase

        n_rsp.overflow = ovf;
        if (ovf) begin
            n_rsp.result_value = '0;
        end else if (i_data.kind != cia_pkg::K_PASS && i_data.negres) begin
            n_rsp.result_value = ~mag + 1'b1;
        end else begin
            n_rsp.result_value = mag;
        end
    end

    // Response register.
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

@@ rtl/checked_integer_alu_top.sv @@
// Checked integer ALU: add, subtract, multiply, divide and negate on 32-bit
// operands, signed or unsigned, with an overflow flag and a zero result on
// overflow, division by zero or an unknown operation. It accepts one request
// every cycle while o_in_stall is low and answers each one through a front
// stage, a chain of 32 cells that each do one multiply or divide bit step,
// and a response register, in request order. Every stage holds its own valid
// bit, so bubbles fill up while the output is stalled. Depends on cia_pkg,
// cia_prep, cia_cell, cia_post and checked_integer_alu_top_defines.svh.
`include "checked_integer_alu_top_defines.svh"

module checked_integer_alu_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cia_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cia_pkg::t_rsp o_out_rsp
);

    localparam int W = cia_pkg::WIDTH;

    logic            c_valid [W+1];
    logic            c_stall [W+1];
    cia_pkg::t_stage c_data  [W+1];

    // Decode stage.
    cia_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_req   (i_in_req),
        .o_stall (o_in_stall),
        .o_valid (c_valid[0]),
        .o_data  (c_data[0]),
        .i_stall (c_stall[0])
    );

    // Chain of bit-step cells.
    for (genvar k = 0; k < W; k++) begin : g_cell
        cia_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_data  (c_data[k]),
            .o_stall (c_stall[k]),
            .o_valid (c_valid[k+1]),
            .o_data  (c_data[k+1]),
            .i_stall (c_stall[k+1])
        );
    end

    // Response stage.
    cia_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[W]),
        .i_data  (c_data[W]),
        .o_stall (c_stall[W]),
        .o_valid (o_out_valid),
        .o_rsp   (o_out_rsp),
        .i_stall (i_out_stall)
    );

    // A flagged response always carries a zero result.
    `CIA_ASSERT_SAME(a_ovf_zero, i_clk, i_rst_n, o_out_valid && o_out_rsp.overflow, o_out_rsp.result_value == '0)
    // Backpressure at the input can only come from a stalled, valid output.
    `CIA_ASSERT_SAME(a_stall_src, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    // A division that enters the chain never has a zero divisor.
    `CIA_ASSERT_SAME(a_div_nz, i_clk, i_rst_n, c_valid[0] && (c_data[0].kind == cia_pkg::K_DIV), c_data[0].y != '0)

endmodule
